### design/fvl_pkg.sv
package fvl_pkg;

   // sector and cluster thresholds
   localparam logic [31:0] FAT12_SECT_LIMIT       = 32'd8400;
   localparam logic [31:0] FAT16_SECT_LIMIT       = 32'd1048576;
   localparam logic [31:0] FAT12_CLUSTER_LIMIT    = 32'd4096;
   localparam logic [31:0] FAT16_CLUSTER_LIMIT    = 32'd65536;
   localparam logic [31:0] FAT32_CLUSTER_LIMIT    = 32'd2097152;
   localparam logic [31:0] ROOT_DIR_BYTES         = 32'd16384;
   localparam logic [63:0] FAT32_RESERVED_SECTORS = 64'd32;
   localparam logic [63:0] SECTOR_COUNT_MAX       = 64'h0000_0000_FFFF_FFFF;

   // log2 limits
   localparam logic [4:0] MAX_SECTOR_LOG2        = 5'd12;
   localparam logic [4:0] MAX_CLUSTER_BYTES_LOG2 = 5'd15;
   localparam logic [2:0] MAX_SPC_LOG2           = 3'd7;
   localparam logic [3:0] MIN_SECTOR_LOG2        = 4'd9;
   localparam logic [3:0] BLOCK_SIZE_LOG2_RESET  = 4'd9;

   // shared arithmetic unit
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_SHR,
      ALU_SHL
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [4:0] shamt;
   } alu_ctl_type;

   typedef enum logic [1:0] {
      KIND_FAT12 = 2'd0,
      KIND_FAT16 = 2'd1,
      KIND_FAT32 = 2'd2
   } fat_kind_type;

   // sequencer steps
   typedef enum logic [4:0] {
      S_IDLE,
      S_BPS,
      S_CHOP,
      S_KIND,
      S_SPC,
      S_RES,
      S_EST1,
      S_EST2,
      S_EST3,
      S_FATB,
      S_FB1,
      S_FB2,
      S_CL1,
      S_CL2,
      S_CL3,
      S_CL4,
      S_CL5,
      S_SPAN,
      S_L1,
      S_L2,
      S_L3,
      S_DONE
   } state_type;

endpackage

### design/fat_volume_layout_calc_top.sv
// fat volume layout calculator: one transaction at a time through a shared 64-bit alu
// the sequencer walks its steps from accept to rsp_valid; the sector-size search, the device chop
// and the cluster-size search add steps that depend on the block count
// oversized block size: the sequencer goes from idle straight to done; a new transaction is taken
// only when idle, and one is taken while the previous result waits on rsp_stall
// synchronous active-high reset: sequencer idle, no result pending, block_size_log2 = 9
module fat_volume_layout_calc_top import fvl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_block_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_size_error,
   output logic [1:0]  rsp_fat_kind,
   output logic [3:0]  rsp_sector_size_log2,
   output logic [4:0]  rsp_cluster_blocks_log2,
   output logic [63:0] rsp_reserved_block_count,
   output logic [63:0] rsp_root_block_count,
   output logic [63:0] rsp_fat_block_count,
   output logic [63:0] rsp_logical_block_count,
   output logic [31:0] rsp_cluster_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_block_size_log2
);

   state_type    state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [3:0]   lbs_ff, lbs_in;

   logic [63:0]  nblk_ff, nblk_in;
   logic         err_ff, err_in;
   logic [3:0]   bps_ff, bps_in;
   logic [2:0]   spc_ff, spc_in;
   fat_kind_type kind_ff, kind_in;
   logic [31:0]  limit_ff, limit_in;
   logic [31:0]  nsect_ff, nsect_in;
   logic [63:0]  reserved_ff, reserved_in;
   logic [63:0]  fat_ff, fat_in;
   logic [63:0]  root_ff, root_in;
   logic [63:0]  acc_ff, acc_in;
   logic [31:0]  clusters_ff, clusters_in;
   logic [31:0]  span_ff, span_in;
   logic [63:0]  logical_ff, logical_in;

   logic         rsp_err_ff;
   logic [1:0]   rsp_kind_ff;
   logic [3:0]   rsp_sect_ff;
   logic [4:0]   rsp_bpc_ff;
   logic [63:0]  rsp_reserved_ff;
   logic [63:0]  rsp_root_ff;
   logic [63:0]  rsp_fat_ff;
   logic [63:0]  rsp_logical_ff;
   logic [31:0]  rsp_clusters_ff;

   logic [63:0]  alu_a, alu_b, alu_y;
   alu_ctl_type  alu_ctl;
   logic         load_rsp;

   logic [4:0]   lbs_plus_bps;
   logic [3:0]   sect_log2;
   logic [4:0]   bpc;
   logic [31:0]  blk_mask;

   // derived sizes
   assign lbs_plus_bps = {1'b0, lbs_ff} + {1'b0, bps_ff};
   assign sect_log2    = lbs_plus_bps[3:0];
   assign bpc          = {1'b0, bps_ff} + {2'b00, spc_ff};
   assign blk_mask     = (32'd1 << lbs_ff) - 32'd1;

   fvl_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .ctl (alu_ctl),
      .y   (alu_y)
   );

   // sequencer next state and datapath control
   always_comb begin
      logic        over;
      logic [31:0] est;
      logic [31:0] tri_bytes;
      logic [31:0] copy_bytes;

      over       = 1'b0;
      est        = acc_ff[31:0];
      tri_bytes  = est + {est[30:0], 1'b0} + 32'd1;
      copy_bytes = '0;

      state_in    = state_ff;
      nblk_in     = nblk_ff;
      err_in      = err_ff;
      bps_in      = bps_ff;
      spc_in      = spc_ff;
      kind_in     = kind_ff;
      limit_in    = limit_ff;
      nsect_in    = nsect_ff;
      reserved_in = reserved_ff;
      fat_in      = fat_ff;
      root_in     = root_ff;
      acc_in      = acc_ff;
      clusters_in = clusters_ff;
      span_in     = span_ff;
      logical_in  = logical_ff;
      alu_a       = acc_ff;
      alu_b       = '0;
      alu_ctl     = '{op: ALU_ADD, shamt: 5'd0};
      load_rsp    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               nblk_in = req_block_count;
               if ({1'b0, lbs_ff} > MAX_SECTOR_LOG2) begin
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  err_in   = 1'b0;
                  bps_in   = (lbs_ff < MIN_SECTOR_LOG2) ? MIN_SECTOR_LOG2 - lbs_ff : 4'd0;
                  state_in = S_BPS;
               end
            end
         end
         // grow the sector until the sector count fits 32 bits or the sector reaches its largest size
         S_BPS: begin
            alu_a   = nblk_ff;
            alu_ctl = '{op: ALU_SHR, shamt: {1'b0, bps_ff}};
            over    = alu_y > SECTOR_COUNT_MAX;
            if (over && lbs_plus_bps < MAX_SECTOR_LOG2) begin
               bps_in = bps_ff + 4'd1;
            end else if (over) begin
               state_in = S_CHOP;
            end else begin
               nsect_in = alu_y[31:0];
               state_in = S_KIND;
            end
         end
         // huge device: cut to the largest sector count
         S_CHOP: begin
            alu_a    = SECTOR_COUNT_MAX;
            alu_ctl  = '{op: ALU_SHL, shamt: {1'b0, bps_ff}};
            nblk_in  = alu_y;
            nsect_in = SECTOR_COUNT_MAX[31:0];
            state_in = S_KIND;
         end
         S_KIND: begin
            if (nsect_ff < FAT12_SECT_LIMIT) begin
               kind_in  = KIND_FAT12;
               limit_in = FAT12_CLUSTER_LIMIT;
               spc_in   = 3'd1;
            end else if (nsect_ff < FAT16_SECT_LIMIT) begin
               kind_in  = KIND_FAT16;
               limit_in = FAT16_CLUSTER_LIMIT;
               spc_in   = 3'd1;
            end else begin
               kind_in  = KIND_FAT32;
               limit_in = FAT32_CLUSTER_LIMIT;
               spc_in   = 3'd3;
            end
            root_in  = (nsect_ff < FAT16_SECT_LIMIT) ?
                       {32'd0, ROOT_DIR_BYTES >> lbs_ff} : 64'd0;
            state_in = S_SPC;
         end
         // grow the cluster until the count is within the cluster-count limit or the cluster is at its largest
         S_SPC: begin
            alu_a   = {32'd0, nsect_ff};
            alu_ctl = '{op: ALU_SHR, shamt: {2'b00, spc_ff}};
            if (spc_ff < MAX_SPC_LOG2 &&
                ({1'b0, sect_log2} + {2'b00, spc_ff}) < MAX_CLUSTER_BYTES_LOG2 &&
                alu_y > {32'd0, limit_ff}) begin
               spc_in = spc_ff + 3'd1;
            end else begin
               state_in = S_RES;
            end
         end
         S_RES: begin
            alu_a       = (kind_ff == KIND_FAT32) ? FAT32_RESERVED_SECTORS : 64'd1;
            alu_ctl     = '{op: ALU_SHL, shamt: {1'b0, bps_ff}};
            reserved_in = alu_y;
            state_in    = S_EST1;
         end
         // cluster estimate for fat sizing
         S_EST1: begin
            alu_a    = nblk_ff;
            alu_b    = reserved_ff;
            alu_ctl  = '{op: ALU_SUB, shamt: 5'd0};
            acc_in   = alu_y;
            state_in = S_EST2;
         end
         S_EST2: begin
            alu_ctl  = '{op: ALU_SHR, shamt: bpc};
            acc_in   = alu_y;
            state_in = S_EST3;
         end
         S_EST3: begin
            alu_b    = 64'd2;
            acc_in   = alu_y;
            state_in = S_FATB;
         end
         // fat bytes by entry width
         S_FATB: begin
            unique case (kind_ff)
               KIND_FAT32: copy_bytes = {est[29:0], 2'b00};
               KIND_FAT16: copy_bytes = {est[30:0], 1'b0};
               default:    copy_bytes = {1'b0, tri_bytes[31:1]};
            endcase
            fat_in   = {32'd0, copy_bytes};
            state_in = S_FB1;
         end
         // round fat bytes up to blocks, 32-bit wrap
         S_FB1: begin
            alu_a    = {32'd0, fat_ff[31:0]};
            alu_b    = {32'd0, blk_mask};
            acc_in   = alu_y;
            state_in = S_FB2;
         end
         S_FB2: begin
            alu_a    = {32'd0, acc_ff[31:0]};
            alu_ctl  = '{op: ALU_SHR, shamt: {1'b0, lbs_ff}};
            fat_in   = alu_y;
            state_in = S_CL1;
         end
         // data region and cluster count
         S_CL1: begin
            alu_a    = nblk_ff;
            alu_b    = reserved_ff;
            alu_ctl  = '{op: ALU_SUB, shamt: 5'd0};
            acc_in   = alu_y;
            state_in = S_CL2;
         end
         S_CL2: begin
            alu_b    = root_ff;
            alu_ctl  = '{op: ALU_SUB, shamt: 5'd0};
            acc_in   = alu_y;
            state_in = S_CL3;
         end
         S_CL3: begin
            alu_b    = {fat_ff[62:0], 1'b0};
            alu_ctl  = '{op: ALU_SUB, shamt: 5'd0};
            acc_in   = alu_y;
            state_in = S_CL4;
         end
         S_CL4: begin
            alu_ctl  = '{op: ALU_SHR, shamt: bpc};
            acc_in   = alu_y;
            state_in = S_CL5;
         end
         // acc keeps clusters minus two for the span
         S_CL5: begin
            alu_b       = 64'd2;
            clusters_in = alu_y[31:0];
            state_in    = S_SPAN;
         end
         S_SPAN: begin
            alu_a    = {32'd0, acc_ff[31:0]};
            alu_ctl  = '{op: ALU_SHL, shamt: bpc};
            span_in  = alu_y[31:0];
            state_in = S_L1;
         end
         // span plus fats plus reserved
         S_L1: begin
            alu_a    = {32'd0, span_ff};
            alu_b    = {fat_ff[62:0], 1'b0};
            acc_in   = alu_y;
            state_in = S_L2;
         end
         S_L2: begin
            alu_b    = reserved_ff;
            acc_in   = alu_y;
            state_in = S_L3;
         end
         // fat12 and fat16: fixed root takes the slack, so the layout covers the whole device; fat32 ends at the span
         S_L3: begin
            alu_a   = nblk_ff;
            alu_b   = acc_ff;
            alu_ctl = '{op: ALU_SUB, shamt: 5'd0};
            if (kind_ff != KIND_FAT32) begin
               root_in    = alu_y;
               logical_in = nblk_ff;
            end else begin
               logical_in = acc_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared when the transaction is taken; block size loaded on csr_valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
      lbs_in = lbs_ff;
      if (csr_valid) begin
         lbs_in = csr_block_size_log2;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lbs_ff       <= BLOCK_SIZE_LOG2_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lbs_ff       <= lbs_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      nblk_ff     <= nblk_in;
      err_ff      <= err_in;
      bps_ff      <= bps_in;
      spc_ff      <= spc_in;
      kind_ff     <= kind_in;
      limit_ff    <= limit_in;
      nsect_ff    <= nsect_in;
      reserved_ff <= reserved_in;
      fat_ff      <= fat_in;
      root_ff     <= root_in;
      acc_ff      <= acc_in;
      clusters_ff <= clusters_in;
      span_ff     <= span_in;
      logical_ff  <= logical_in;
   end

   // output register, all zero but the error flag on an oversized block
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_err_ff      <= err_ff;
         rsp_kind_ff     <= err_ff ? 2'd0 : kind_ff;
         rsp_sect_ff     <= err_ff ? 4'd0 : sect_log2;
         rsp_bpc_ff      <= err_ff ? 5'd0 : bpc;
         rsp_reserved_ff <= err_ff ? 64'd0 : reserved_ff;
         rsp_root_ff     <= err_ff ? 64'd0 : root_ff;
         rsp_fat_ff      <= err_ff ? 64'd0 : fat_ff;
         rsp_logical_ff  <= err_ff ? 64'd0 : logical_ff;
         rsp_clusters_ff <= err_ff ? 32'd0 : clusters_ff;
      end
   end

   assign req_stall               = (state_ff != S_IDLE);
   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_size_error          = rsp_err_ff;
   assign rsp_fat_kind            = rsp_kind_ff;
   assign rsp_sector_size_log2    = rsp_sect_ff;
   assign rsp_cluster_blocks_log2 = rsp_bpc_ff;
   assign rsp_reserved_block_count = rsp_reserved_ff;
   assign rsp_root_block_count    = rsp_root_ff;
   assign rsp_fat_block_count     = rsp_fat_ff;
   assign rsp_logical_block_count = rsp_logical_ff;
   assign rsp_cluster_count       = rsp_clusters_ff;

endmodule

### design/fvl_alu.sv
module fvl_alu import fvl_pkg::*; (
   input  logic [63:0] a,
   input  logic [63:0] b,
   input  alu_ctl_type ctl,
   output logic [63:0] y
);

   // one add, subtract or barrel shift per cycle
   always_comb begin
      unique case (ctl.op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         ALU_SHR: y = a >> ctl.shamt;
         ALU_SHL: y = a << ctl.shamt;
      endcase
   end

endmodule
